[rtl/zone_bitmap_allocator_defines.svh]
// Assertion macros for the zone bitmap allocator.
`ifndef ZONE_BITMAP_ALLOCATOR_DEFINES_SVH
`define ZONE_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ZBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ZBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/zba_pkg.sv]
// Shared types and constants for the zone bitmap allocator.
package zba_pkg;

    localparam int MAP_BITS  = 65536;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int KW        = WORD_AW + BIT_AW;

    localparam logic [WORD_BITS-1:0] RESET_WORD0 = 64'h01;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FREED = 2'd3;

    localparam logic CFG_FIRST_DATA_ZONE = 1'b0;
    localparam logic CFG_ZONE_COUNT      = 1'b1;

    localparam logic [15:0] FIRST_DATA_ZONE_RESET = 16'd1;
    localparam logic [15:0] ZONE_COUNT_RESET      = 16'd65535;

    typedef struct packed {
        logic        op;
        logic [15:0] block_number;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] allocated_block;
    } rsp_t;

endpackage

[rtl/zone_bitmap_allocator.sv]
// Flow: an allocate reads bitmap words in order from word 0 until it finds a free bit
// or checks the last word (1 to 1024 words scanned); a free checks its range first and
// answers from that check when out of range, else reads its word and clears the bit if
// set. One request at a time: the next is taken once the last has answered; output stalls add delay.
// Reset: a clearing pass writes all 1024 bitmap words, one per cycle, before the first
// request is taken; config registers reset to first_data_zone 1, zone_count 65535.
module zone_bitmap_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic          cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic          req_valid,
    output logic          req_stall,
    input  zba_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output zba_pkg::rsp_t rsp
);

`include "zone_bitmap_allocator_defines.svh"

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_A_CHK  = 3'd2;
    localparam logic [2:0] S_F_CALC = 3'd3;
    localparam logic [2:0] S_F_CHK  = 3'd4;

    localparam int WB = zba_pkg::WORD_BITS;
    localparam int WA = zba_pkg::WORD_AW;
    localparam int BA = zba_pkg::BIT_AW;
    localparam int KW = zba_pkg::KW;

    // bitmap memory
    logic [WB-1:0] mem [zba_pkg::MAP_WORDS];
    logic [WB-1:0] rdata_reg;
    logic          mem_we;
    logic [WA-1:0] mem_waddr;
    logic [WB-1:0] mem_wdata;
    logic          rd_en;
    logic [WA-1:0] rd_addr;

    // control
    logic [2:0]    state_reg, state_next;
    logic [WA-1:0] clr_reg, clr_next;
    logic [15:0]   fdz_reg, fdz_next;
    logic [15:0]   zc_reg, zc_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload
    logic [WA-1:0]     w_reg, w_next;
    logic [BA-1:0]     bit_reg, bit_next;
    logic [KW-1:0]     last_reg, last_next;
    logic              empty_reg, empty_next;
    logic [15:0]       blk_reg, blk_next;
    zba_pkg::rsp_t     rsp_reg, rsp_next;

    // datapath
    logic              out_free;
    logic              rsp_load;
    zba_pkg::rsp_t     rsp_load_data;
    logic [16:0]       span;
    logic [WB-1:0]     top_mask;
    logic              at_last;
    logic [WB-1:0]     free_bits;
    logic [WB-1:0]     low_bit;
    logic [BA-1:0]     low_pos;
    logic [KW-1:0]     alloc_k;
    logic [16:0]       free_k;
    logic              free_bad;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // last scanned bit = zone_count - first_data_zone, clamped to the map
    assign span = {1'b0, zc_reg} - {1'b0, fdz_reg};

    assign at_last = (w_reg == last_reg[KW-1:BA]);

    always_comb
    begin
        for (int i = 0; i < WB; i++)
        begin
            top_mask[i] = (BA'(i) <= last_reg[BA-1:0]);
        end
    end

    assign free_bits = ~rdata_reg & (at_last ? top_mask : {WB{1'b1}});
    assign low_bit   = free_bits & (~free_bits + {{(WB-1){1'b0}}, 1'b1});

    always_comb
    begin
        low_pos = '0;
        for (int i = 0; i < WB; i++)
        begin
            if (low_bit[i])
            begin
                low_pos = low_pos | BA'(i);
            end
        end
    end

    assign alloc_k = {w_reg, low_pos};

    assign free_k   = {1'b0, blk_reg} - {1'b0, fdz_reg} + 17'd1;
    assign free_bad = (blk_reg < fdz_reg) || (blk_reg >= zc_reg)
                   || (free_k >= 17'(zba_pkg::MAP_BITS));

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        w_next        = w_reg;
        bit_next      = bit_reg;
        last_next     = last_reg;
        empty_next    = empty_reg;
        blk_next      = blk_reg;
        mem_we        = 1'b0;
        mem_waddr     = w_reg;
        mem_wdata     = rdata_reg;
        rd_en         = 1'b0;
        rd_addr       = w_reg;
        rsp_load      = 1'b0;
        rsp_load_data = '{status: zba_pkg::ST_OK, allocated_block: 16'd0};

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == '0) ? zba_pkg::RESET_WORD0 : '0;
                clr_next  = WA'(clr_reg + 1'b1);
                if (clr_reg == WA'(zba_pkg::MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.op == zba_pkg::OP_ALLOC)
                    begin
                        empty_next = span[16];
                        last_next  = (span > 17'(zba_pkg::MAP_BITS - 1))
                                   ? KW'(zba_pkg::MAP_BITS - 1) : KW'(span);
                        w_next     = '0;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_A_CHK;
                    end
                    else
                    begin
                        blk_next   = req.block_number;
                        state_next = S_F_CALC;
                    end
                end
            end
            S_A_CHK:
            begin
                if (empty_reg || (free_bits == '0 && at_last))
                begin
                    if (out_free)
                    begin
                        rsp_load      = 1'b1;
                        rsp_load_data = '{status: zba_pkg::ST_FULL, allocated_block: 16'd0};
                        state_next    = S_IDLE;
                    end
                end
                else if (free_bits != '0)
                begin
                    // claim the lowest free bit only once the result can go out
                    if (out_free)
                    begin
                        mem_we        = 1'b1;
                        mem_waddr     = w_reg;
                        mem_wdata     = rdata_reg | low_bit;
                        rsp_load      = 1'b1;
                        rsp_load_data = '{status: zba_pkg::ST_OK,
                                          allocated_block: 16'(fdz_reg + 16'(alloc_k) - 16'd1)};
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = WA'(w_reg + 1'b1);
                    w_next  = WA'(w_reg + 1'b1);
                end
            end
            S_F_CALC:
            begin
                if (free_bad)
                begin
                    if (out_free)
                    begin
                        rsp_load      = 1'b1;
                        rsp_load_data = '{status: zba_pkg::ST_RANGE, allocated_block: 16'd0};
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = free_k[KW-1:BA];
                    w_next     = free_k[KW-1:BA];
                    bit_next   = free_k[BA-1:0];
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                    if (!rdata_reg[bit_reg])
                    begin
                        rsp_load_data = '{status: zba_pkg::ST_FREED, allocated_block: 16'd0};
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = w_reg;
                        mem_wdata = rdata_reg & ~({{(WB-1){1'b0}}, 1'b1} << bit_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fdz_next = fdz_reg;
        zc_next  = zc_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                zba_pkg::CFG_FIRST_DATA_ZONE: fdz_next = cfg_data;
                zba_pkg::CFG_ZONE_COUNT:      zc_next  = cfg_data;
                default:                      fdz_next = fdz_reg;
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = rsp_load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            fdz_reg       <= zba_pkg::FIRST_DATA_ZONE_RESET;
            zc_reg        <= zba_pkg::ZONE_COUNT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fdz_reg       <= fdz_next;
            zc_reg        <= zc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        bit_reg   <= bit_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        blk_reg   <= blk_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ZBA_ASSERT_NOW(a_scan_in_range, (state_reg == S_A_CHK) && !empty_reg,
        w_reg <= last_reg[KW-1:BA], "bitmap scan passed the last word")
    `ZBA_ASSERT_NOW(a_block_only_on_ok, rsp_valid_reg && (rsp_reg.status != zba_pkg::ST_OK),
        rsp_reg.allocated_block == 16'd0, "failed request carries a block number")
    `ZBA_ASSERT_NOW(a_write_states, mem_we,
        (state_reg == S_CLEAR) || (state_reg == S_A_CHK) || (state_reg == S_F_CHK),
        "bitmap written outside clear, claim or release")
    `ZBA_ASSERT_NEXT(a_load_sets_valid, rsp_load, rsp_valid_reg,
        "completed request did not raise response valid")

endmodule
